>>> src/cdt_pkg.sv
// Shared constants, types and the byte-wide CRC-32 step for the dedup table.
`timescale 1ns / 1ps
package cdt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

	// finished blob handed from the CRC front end to the chain
	typedef struct packed {
		logic        kind;
		logic [31:0] hash;
		logic [31:0] blob_len;
	} blob_t;

	// search word travelling down the row of cells
	typedef struct packed {
		logic             valid;
		logic             kind;
		logic [31:0]      hash;
		logic [31:0]      blob_len;
		logic [CNT_W-1:0] count;
		logic             found;
		logic [31:0]      uses;
		logic [31:0]      ent_len;
	} tok_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> src/cdt_crc.sv
// Byte-wide CRC-32 and length accumulator; emits one finished blob per last byte.
`timescale 1ns / 1ps
module cdt_crc (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic           kind,
	input  logic [7:0]     data_byte,
	input  logic           byte_present,
	input  logic           last_byte,
	output logic           done,
	output cdt_pkg::blob_t blob
);
	import cdt_pkg::*;

	logic [31:0] crc_q;
	logic [31:0] len_q;
	logic [31:0] crc_nxt;
	logic [31:0] len_nxt;
	logic        done_s1;
	blob_t       blob_s1;

	always_comb begin
		crc_nxt = crc_q;
		len_nxt = len_q;
		if (byte_present) begin
			crc_nxt = crc_byte(crc_q, data_byte);
			len_nxt = len_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_PRESET;
			len_q   <= '0;
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= take && last_byte;
			if (take) begin
				if (last_byte) begin
					crc_q <= CRC_PRESET;
					len_q <= '0;
				end else begin
					crc_q <= crc_nxt;
					len_q <= len_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_byte) begin
			blob_s1.kind     <= kind;
			blob_s1.hash     <= ~crc_nxt;
			blob_s1.blob_len <= len_nxt;
		end
	end

	assign done = done_s1;
	assign blob = blob_s1;

endmodule

>>> src/cdt_cell.sv
// One table entry: compares, bumps or takes an insert as the search word passes.
`timescale 1ns / 1ps
module cdt_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [cdt_pkg::IDX_W-1:0] idx,
	input  cdt_pkg::tok_t            tok_in,
	output cdt_pkg::tok_t            tok_out
);
	import cdt_pkg::*;

	logic [31:0]      hash_q;
	logic [31:0]      len_q;
	logic [31:0]      uses_q;
	tok_t             tok_q;
	tok_t             tok_nxt;
	logic [CNT_W-1:0] idx_ext;
	logic             live;
	logic             hit;
	logic             ins;
	logic             is_add;

	assign idx_ext = CNT_W'(idx);
	assign is_add  = (tok_in.kind == KIND_ADD);
	assign live    = tok_in.valid && !tok_in.found;
	assign hit     = live && (idx_ext < tok_in.count) && (hash_q == tok_in.hash);
	assign ins     = live && is_add && (idx_ext == tok_in.count);

	always_comb begin
		tok_nxt = tok_in;
		if (hit) begin
			tok_nxt.found   = 1'b1;
			tok_nxt.uses    = is_add ? (uses_q + 32'd1) : uses_q;
			tok_nxt.ent_len = len_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			hash_q <= tok_in.hash;
			len_q  <= tok_in.blob_len;
			uses_q <= 32'd1;
		end else if (hit && is_add) begin
			uses_q <= uses_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

>>> src/crc32_dedup_table.sv
// Top level of the CRC-32 dedup table: byte front end, row of entry cells, totals, result.
//
//  channel | direction | handshake          | word
//  in      | into      | in_valid/in_ready   | kind, data_byte, byte_present, last_byte
//  out     | out of    | out_valid/out_ready | blob_hash ... table_full, one per blob end
//
// Bytes are taken one per cycle. A last byte sends the blob's hash down the row of
// TABLE_DEPTH cells, one cell per cycle, so input is held off after a last byte is
// taken until its result moves from the pending to the output register (longer if
// the previous result is still unread). Reset clears the CRC, counters and totals;
// table entries are only read below the entry count. A stalled result sits in the
// output register while the next blob's bytes stream in.
`timescale 1ns / 1ps
module crc32_dedup_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      kind,
	input  logic [7:0]                data_byte,
	input  logic                      byte_present,
	input  logic                      last_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [31:0]               blob_hash,
	output logic                      was_duplicate,
	output logic [31:0]               use_count,
	output logic [cdt_pkg::CNT_W-1:0] stored_entries,
	output logic [31:0]               added_blobs,
	output logic [31:0]               total_bytes,
	output logic [31:0]               saved_bytes,
	output logic                      table_full
);
	import cdt_pkg::*;

	typedef struct packed {
		logic [31:0]      hash;
		logic             dup;
		logic [31:0]      uses;
		logic [CNT_W-1:0] entries;
		logic [31:0]      blobs;
		logic [31:0]      bytes;
		logic [31:0]      saved;
		logic             full;
	} res_t;

	logic             take;
	logic             blob_done;
	blob_t            blob;
	tok_t             chain [TABLE_DEPTH+1];
	tok_t             ex;
	logic             busy_q;
	logic             pend_valid_q;
	res_t             pend_q;
	logic             out_valid_q;
	res_t             out_q;
	logic [CNT_W-1:0] entry_total_q;
	logic [31:0]      blob_total_q;
	logic [31:0]      byte_total_q;
	logic [31:0]      uniq_total_q;
	logic [CNT_W-1:0] entry_total_nxt;
	logic [31:0]      blob_total_nxt;
	logic [31:0]      byte_total_nxt;
	logic [31:0]      uniq_total_nxt;
	res_t             res;
	logic             ex_add;
	logic             ex_ins;
	logic             move;

	assign in_ready = !busy_q;
	assign take     = in_valid && in_ready;

	cdt_crc u_crc (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.kind         (kind),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.last_byte    (last_byte),
		.done         (blob_done),
		.blob         (blob)
	);

	always_comb begin
		chain[0]          = '0;
		chain[0].valid    = blob_done;
		chain[0].kind     = blob.kind;
		chain[0].hash     = blob.hash;
		chain[0].blob_len = blob.blob_len;
		chain[0].count    = entry_total_q;
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		cdt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(i)),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	assign ex     = chain[TABLE_DEPTH];
	assign ex_add = (ex.kind == KIND_ADD);
	assign ex_ins = ex_add && !ex.found && (ex.count < CNT_W'(TABLE_DEPTH));

	always_comb begin
		entry_total_nxt = entry_total_q;
		blob_total_nxt  = blob_total_q;
		byte_total_nxt  = byte_total_q;
		uniq_total_nxt  = uniq_total_q;
		res             = '0;
		res.hash        = ex.hash;
		if (ex_add) begin
			if (ex.found) begin
				blob_total_nxt = blob_total_q + 32'd1;
				byte_total_nxt = byte_total_q + ex.ent_len;
				res.dup        = 1'b1;
				res.uses       = ex.uses;
			end else if (ex_ins) begin
				entry_total_nxt = entry_total_q + CNT_W'(1);
				blob_total_nxt  = blob_total_q + 32'd1;
				byte_total_nxt  = byte_total_q + ex.blob_len;
				uniq_total_nxt  = uniq_total_q + ex.blob_len;
				res.uses        = 32'd1;
			end else begin
				res.full = 1'b1;
			end
		end else if (ex.found) begin
			res.dup  = 1'b1;
			res.uses = ex.uses;
		end
		res.entries = entry_total_nxt;
		res.blobs   = blob_total_nxt;
		res.bytes   = byte_total_nxt;
		res.saved   = byte_total_nxt - uniq_total_nxt;
	end

	assign move = pend_valid_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
			entry_total_q <= '0;
			blob_total_q  <= '0;
			byte_total_q  <= '0;
			uniq_total_q  <= '0;
		end else begin
			if (take && last_byte) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (ex.valid) begin
				pend_valid_q  <= 1'b1;
				entry_total_q <= entry_total_nxt;
				blob_total_q  <= blob_total_nxt;
				byte_total_q  <= byte_total_nxt;
				uniq_total_q  <= uniq_total_nxt;
			end else if (move) begin
				pend_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ex.valid) begin
			pend_q <= res;
		end
		if (move) begin
			out_q <= pend_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign blob_hash      = out_q.hash;
	assign was_duplicate  = out_q.dup;
	assign use_count      = out_q.uses;
	assign stored_entries = out_q.entries;
	assign added_blobs    = out_q.blobs;
	assign total_bytes    = out_q.bytes;
	assign saved_bytes    = out_q.saved;
	assign table_full     = out_q.full;

	a_exit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ex.valid |-> busy_q)
		else $error("search word left the row with no blob in flight");

	a_pend_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> !in_ready)
		else $error("input taken while a result is still pending");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_total_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_full_not_dup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.full && out_q.dup))
		else $error("result flagged both full and duplicate");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		blob_done |-> !pend_valid_q && !ex.valid)
		else $error("new search started while another was in flight");

endmodule
